// ===== rtl/bphf_pkg.sv =====
`timescale 1ns / 1ps

package bphf_pkg;

  // Hysteresis counter width and threshold register width.
  localparam int unsigned CNT_W = 6;
  localparam int unsigned THR_W = 6;
  localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int unsigned NPH   = 4;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned PH_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Phase codes.
  localparam logic [PH_W-1:0] PH_NONE     = 3'd0;
  localparam logic [PH_W-1:0] PH_OURS     = 3'd1;
  localparam logic [PH_W-1:0] PH_STANDOFF = 3'd2;
  localparam logic [PH_W-1:0] PH_WAIT     = 3'd3;
  localparam logic [PH_W-1:0] PH_GIVEUP   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_OURS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_STANDOFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_WAIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_GIVEUP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_OURS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_STANDOFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_WAIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_GIVEUP   = 3'd7;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_SCAN,
    OP_ENTER,
    OP_KEEP,
    OP_DEC
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [NPH-1:0]   hit;
    logic             act_cond;
    logic             act_low;
    logic [THR_W-1:0] act_count;
  } dp_sts_t;

  function automatic logic [CMP_W-1:0] wide_cnt(input logic [CNT_W-1:0] c);
    return CMP_W'(c);
  endfunction

  function automatic logic [CMP_W-1:0] wide_thr(input logic [THR_W-1:0] t);
    return CMP_W'(t);
  endfunction

  // Keep threshold limited to what the counter can hold.
  function automatic logic [CNT_W-1:0] cap_keep(input logic [THR_W-1:0] k);
    logic [CMP_W-1:0] w;
    w = wide_thr(k);
    if (w > wide_cnt(CNT_MAX)) begin
      return CNT_MAX;
    end
    return w[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [THR_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = wide_cnt(c);
    return w[THR_W-1:0];
  endfunction

endpackage

// ===== rtl/bphf_dp.sv =====
`timescale 1ns / 1ps

module bphf_dp
  import bphf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  input  logic                 ours_i,
  input  logic                 standoff_i,
  input  logic                 wait_i,
  input  logic                 giveup_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o
);

  logic [THR_W-1:0] jump_q [NPH];
  logic [THR_W-1:0] keep_q [NPH];
  logic [CNT_W-1:0] cnt_q  [NPH];
  logic [CNT_W-1:0] cnt_d  [NPH];
  logic [NPH-1:0]   cond;
  logic [CNT_W-1:0] act_cnt;
  logic [CNT_W-1:0] act_inc;
  logic [CNT_W-1:0] act_keep;

  // Stand-off only counts when the ball is not already ours.
  assign cond = {giveup_i, wait_i, standoff_i & ~ours_i, ours_i};

  assign act_cnt  = cnt_q[cmd_i.idx];
  assign act_inc  = sat_inc(act_cnt);
  assign act_keep = cap_keep(keep_q[cmd_i.idx]);

  always_comb begin
    for (int i = 0; i < NPH; i++) begin
      sts_o.hit[i] = cond[i] && (wide_cnt(sat_inc(cnt_q[i])) >= wide_thr(jump_q[i]));
    end
    sts_o.act_cond  = cond[cmd_i.idx];
    sts_o.act_low   = (act_cnt <= CNT_W'(1));
    sts_o.act_count = cnt_to_out(act_cnt);
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case (cmd_i.op)
      OP_HOLD: begin
      end
      OP_CLEAR: begin
        for (int i = 0; i < NPH; i++) begin
          cnt_d[i] = '0;
        end
      end
      OP_SCAN: begin
        for (int i = 0; i < NPH; i++) begin
          if (cond[i]) begin
            cnt_d[i] = sat_inc(cnt_q[i]);
          end else if (cnt_q[i] != '0) begin
            cnt_d[i] = cnt_q[i] - CNT_W'(1);
          end
        end
      end
      OP_ENTER: begin
        for (int i = 0; i < NPH; i++) begin
          cnt_d[i] = '0;
        end
        cnt_d[cmd_i.idx] = act_keep;
      end
      OP_KEEP: begin
        cnt_d[cmd_i.idx] = (act_inc < act_keep) ? act_inc : act_keep;
      end
      OP_DEC: begin
        cnt_d[cmd_i.idx] = act_cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPH; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q[0] <= THR_W'(5);
      jump_q[1] <= THR_W'(15);
      jump_q[2] <= THR_W'(5);
      jump_q[3] <= THR_W'(5);
      keep_q[0] <= THR_W'(8);
      keep_q[1] <= THR_W'(45);
      keep_q[2] <= THR_W'(5);
      keep_q[3] <= THR_W'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_JUMP_OURS:     jump_q[0] <= cfg_data_i;
        REG_JUMP_STANDOFF: jump_q[1] <= cfg_data_i;
        REG_JUMP_WAIT:     jump_q[2] <= cfg_data_i;
        REG_JUMP_GIVEUP:   jump_q[3] <= cfg_data_i;
        REG_KEEP_OURS:     keep_q[0] <= cfg_data_i;
        REG_KEEP_STANDOFF: keep_q[1] <= cfg_data_i;
        REG_KEEP_WAIT:     keep_q[2] <= cfg_data_i;
        REG_KEEP_GIVEUP:   keep_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/bphf_ctrl.sv =====
`timescale 1ns / 1ps

module bphf_ctrl
  import bphf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic            clear_i,
  input  logic            best_chg_i,
  input  logic            toucher_chg_i,
  input  dp_sts_t         sts_i,
  output dp_cmd_t         cmd_o,
  output logic [PH_W-1:0] phase_o
);

  logic [PH_W-1:0] phase_q, phase_d;
  logic            valid_q, valid_d;
  logic            accept;
  logic            abort;
  logic [PH_W-1:0] phase_m1;

  // The output holds the state left by the last transaction, so a new one
  // may be taken as soon as the pending result leaves.
  assign in_ready_o  = ~valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = valid_q;
  assign phase_o     = phase_q;

  assign phase_m1 = phase_q - PH_W'(1);
  assign abort = ((phase_q == PH_STANDOFF) && best_chg_i) ||
                 ((phase_q == PH_WAIT) && toucher_chg_i);

  always_comb begin
    phase_d   = phase_q;
    cmd_o.op  = OP_HOLD;
    cmd_o.idx = phase_m1[IDX_W-1:0];
    if (accept) begin
      if (clear_i) begin
        cmd_o.op = OP_CLEAR;
        phase_d  = PH_NONE;
      end else begin
        unique case (phase_q)
          PH_NONE: begin
            cmd_o.op = OP_SCAN;
            priority if (sts_i.hit[0]) begin
              cmd_o.op = OP_ENTER;
              cmd_o.idx = IDX_W'(0);
              phase_d   = PH_OURS;
            end else if (sts_i.hit[1]) begin
              cmd_o.op = OP_ENTER;
              cmd_o.idx = IDX_W'(1);
              phase_d   = PH_STANDOFF;
            end else if (sts_i.hit[2]) begin
              cmd_o.op = OP_ENTER;
              cmd_o.idx = IDX_W'(2);
              phase_d   = PH_WAIT;
            end else if (sts_i.hit[3]) begin
              cmd_o.op = OP_ENTER;
              cmd_o.idx = IDX_W'(3);
              phase_d   = PH_GIVEUP;
            end else begin
            end
          end
          PH_OURS, PH_STANDOFF, PH_WAIT, PH_GIVEUP: begin
            if (abort) begin
              cmd_o.op = OP_CLEAR;
              phase_d  = PH_NONE;
            end else if (sts_i.act_cond) begin
              cmd_o.op = OP_KEEP;
            end else if (sts_i.act_low) begin
              cmd_o.op = OP_CLEAR;
              phase_d  = PH_NONE;
            end else begin
              cmd_o.op = OP_DEC;
            end
          end
          default: begin
            cmd_o.op = OP_CLEAR;
            phase_d  = PH_NONE;
          end
        endcase
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NONE;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/ball_phase_hysteresis_fsm.sv =====
`timescale 1ns / 1ps

// Ball phase hysteresis mode machine. One frame per input transaction; each
// frame gives exactly one result (phase and active counter) on the master side
// in the cycle after it is taken. A new frame is taken every clock cycle as long
// as the previous result is taken at the same time, so the block sustains one
// frame per cycle; the single output register is the only limit, and a stalled
// result holds off the next frame. The action flag on tuser clears the mode and
// all counters. The user must write thresholds through the cfg port only while the
// block is idle; the block does not enforce this. They apply on the next frame.
module ball_phase_hysteresis_fsm
  import bphf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // ball_is_ours, standoff_seen, wait_ok, giveup_ok, best_player_changed,
  // toucher_changed, zero pad
  input  logic [7:0]           s_axis_tdata_i,
  // action
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // ball_phase [2:0], phase_count [8:3], zero pad
  output logic [15:0]          m_axis_tdata_o
);

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [PH_W-1:0] phase;
  logic [THR_W-1:0] count_out;

  bphf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .clear_i       (s_axis_tuser_i),
    .best_chg_i    (s_axis_tdata_i[4]),
    .toucher_chg_i (s_axis_tdata_i[5]),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .phase_o       (phase)
  );

  bphf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ours_i     (s_axis_tdata_i[0]),
    .standoff_i (s_axis_tdata_i[1]),
    .wait_i     (s_axis_tdata_i[2]),
    .giveup_i   (s_axis_tdata_i[3]),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  assign count_out      = (phase == PH_NONE) ? '0 : sts.act_count;
  assign m_axis_tdata_o = {7'b0, count_out, phase};

`ifndef ASSERT_OFF
  // A clear transaction always leaves the mode at none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> (phase == PH_NONE))
    else $error("clear did not return the mode to none");

  // The mode only changes when a transaction is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid_i && s_axis_tready_o) |=> $stable(phase))
    else $error("mode changed without a transaction");

  // Unused phase codes are never produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase == PH_NONE) || (phase == PH_OURS) || (phase == PH_STANDOFF) ||
    (phase == PH_WAIT) || (phase == PH_GIVEUP))
    else $error("illegal phase code");

  // Entering a phase from none only happens through the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_ENTER) |-> ($past(1'b1) && (phase == PH_NONE) && (sts.hit != '0)))
    else $error("phase entered while another phase was active");
`endif

endmodule
